// ----- hdl/assert_macros.svh -----
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor assertion failed");

// next-cycle implication, checked out of reset
`define CLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor assertion failed");

`endif

// ----- hdl/cle_pkg.sv -----
// types, key codes and ring index helpers for the console line editor
`default_nettype none

package cle_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int IDX_MOD   = 2 * BUF_DEPTH;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int IDX_W     = $clog2(IDX_MOD);

    localparam logic [7:0] KEY_NUL      = 8'h00;
    localparam logic [7:0] KEY_CTRL_D   = 8'h04;
    localparam logic [7:0] KEY_CTRL_H   = 8'h08;
    localparam logic [7:0] KEY_LF       = 8'h0a;
    localparam logic [7:0] KEY_CR       = 8'h0d;
    localparam logic [7:0] KEY_CTRL_P   = 8'h10;
    localparam logic [7:0] KEY_CTRL_U   = 8'h15;
    localparam logic [7:0] KEY_ESC      = 8'h1b;
    localparam logic [7:0] KEY_LBRACKET = 8'h5b;
    localparam logic [7:0] KEY_DEL      = 8'h7f;

    localparam logic [7:0] ERASE_MAX = 8'hff;

    typedef enum logic {
        OP_RECV = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_ECHO   = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_PLIST  = 3'd2,
        KIND_RDATA  = 3'd3,
        KIND_REOF   = 3'd4,
        KIND_REMPTY = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } esc_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
        logic       first_of_read;
    } cle_in_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [7:0] erase_count;
        logic       line_ready;
        logic       end_of_line;
    } cle_out_t;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    function automatic idx_t idx_inc(idx_t a);
        if (a == IDX_W'(IDX_MOD - 1))
            return '0;
        return a + IDX_W'(1);
    endfunction

    function automatic idx_t idx_dec(idx_t a);
        if (a == '0)
            return IDX_W'(IDX_MOD - 1);
        return a - IDX_W'(1);
    endfunction

    function automatic idx_t idx_diff(idx_t a, idx_t b);
        logic [IDX_W:0] t;
        t = {1'b0, a} + (IDX_W + 1)'(IDX_MOD) - {1'b0, b};
        if (a >= b)
            return a - b;
        return t[IDX_W-1:0];
    endfunction

    function automatic addr_t idx_slot(idx_t a);
        idx_t t;
        t = a - IDX_W'(BUF_DEPTH);
        if (a >= IDX_W'(BUF_DEPTH))
            return t[ADDR_W-1:0];
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] erase_sat(idx_t n);
        if (32'(n) > 32'(ERASE_MAX))
            return ERASE_MAX;
        return 8'(n);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cle_line_ram.sv -----
// line store: one write port, one registered read port with write bypass
`default_nettype none

module cle_line_ram (
    input  wire                  clk,
    input  wire                  wr_en,
    input  wire cle_pkg::addr_t  wr_addr,
    input  wire [7:0]            wr_data,
    input  wire cle_pkg::addr_t  rd_addr,
    output logic [7:0]           rd_data
);
    import cle_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/console_line_editor.sv -----
// top level of the console line editor: input register, edit logic, result register
//
//  channel   direction  handshake             payload
//  in        receive    in_valid / in_ready   in_item  (cle_in_t)
//  out       send       out_valid / out_ready out_item (cle_out_t)
//
// one item per cycle while no result is held; a result passes through the input register and then the result register
// all edits are done by the combinational edit logic between the input register and the result register
// the line store read port always holds the byte at the read index
// reset clears the indices and escape phase; store contents stay undefined
// a held result stalls the input register and then in_ready
`default_nettype none

module console_line_editor (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire cle_pkg::cle_in_t  in_item,
    output logic              out_valid,
    input  wire               out_ready,
    output cle_pkg::cle_out_t out_item
);
    import cle_pkg::*;

    logic     in_valid_reg;
    cle_in_t  in_item_reg;
    logic     out_valid_reg;
    cle_out_t out_item_reg;

    idx_t read_index_reg,   read_index_next;
    idx_t commit_index_reg, commit_index_next;
    idx_t edit_index_reg,   edit_index_next;
    esc_t esc_reg,          esc_next;

    logic       proc_go;
    logic       has_result;
    cle_out_t   result;
    logic       wr_en;
    logic [7:0] wr_data;
    logic [7:0] head_byte;
    logic [7:0] rx_char;
    idx_t       fill_cnt;
    idx_t       commit_cnt;
    idx_t       uncommitted;
    idx_t       edit_inc;
    logic       full;

    assign proc_go   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_go;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign fill_cnt    = idx_diff(edit_index_reg, read_index_reg);
    assign commit_cnt  = idx_diff(commit_index_reg, read_index_reg);
    assign uncommitted = idx_diff(edit_index_reg, commit_index_reg);
    assign edit_inc    = idx_inc(edit_index_reg);
    assign full        = fill_cnt >= IDX_W'(BUF_DEPTH);
    assign rx_char     = (in_item_reg.rx_byte == KEY_CR) ? KEY_LF : in_item_reg.rx_byte;

    cle_line_ram u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_slot(edit_index_reg)),
        .wr_data (wr_data),
        .rd_addr (idx_slot(read_index_next)),
        .rd_data (head_byte)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_go)
        begin
            out_valid_reg <= has_result;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go)
        begin
            out_item_reg <= result;
        end
    end

    // ring indices and escape phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_index_reg   <= '0;
            commit_index_reg <= '0;
            edit_index_reg   <= '0;
            esc_reg          <= ESC_NONE;
        end
        else
        begin
            read_index_reg   <= read_index_next;
            commit_index_reg <= commit_index_next;
            edit_index_reg   <= edit_index_next;
            esc_reg          <= esc_next;
        end
    end

    always_comb
    begin
        read_index_next   = read_index_reg;
        commit_index_next = commit_index_reg;
        edit_index_next   = edit_index_reg;
        esc_next          = esc_reg;
        has_result        = 1'b0;
        result            = '0;
        wr_en             = 1'b0;
        wr_data           = rx_char;

        if (proc_go)
        begin
            unique case (in_item_reg.op)
                OP_RECV:
                begin
                    priority if (in_item_reg.rx_byte == KEY_CTRL_P)
                    begin
                        has_result  = 1'b1;
                        result.kind = KIND_PLIST;
                    end
                    else if (in_item_reg.rx_byte == KEY_CTRL_U)
                    begin
                        if (uncommitted != '0)
                        begin
                            edit_index_next    = commit_index_reg;
                            has_result         = 1'b1;
                            result.kind        = KIND_ERASE;
                            result.erase_count = erase_sat(uncommitted);
                        end
                    end
                    else if (in_item_reg.rx_byte == KEY_CTRL_H ||
                             in_item_reg.rx_byte == KEY_DEL)
                    begin
                        if (edit_index_reg != commit_index_reg)
                        begin
                            edit_index_next    = idx_dec(edit_index_reg);
                            has_result         = 1'b1;
                            result.kind        = KIND_ERASE;
                            result.erase_count = 8'd1;
                        end
                    end
                    else if (in_item_reg.rx_byte == KEY_NUL || full)
                    begin
                        // dropped without result
                    end
                    else if (rx_char == KEY_ESC)
                    begin
                        esc_next = ESC_SEEN;
                    end
                    else
                    begin
                        unique case (esc_reg)
                            ESC_SEEN:
                            begin
                                esc_next = (rx_char == KEY_LBRACKET) ? ESC_BRACKET : ESC_NONE;
                            end
                            ESC_BRACKET:
                            begin
                                esc_next = ESC_NONE;
                            end
                            default:
                            begin
                                wr_en           = 1'b1;
                                edit_index_next = edit_inc;
                                has_result      = 1'b1;
                                result.kind     = KIND_ECHO;
                                result.out_byte = rx_char;
                                if (rx_char == KEY_LF || rx_char == KEY_CTRL_D ||
                                    idx_diff(edit_inc, read_index_reg) == IDX_W'(BUF_DEPTH))
                                begin
                                    commit_index_next = edit_inc;
                                    result.line_ready = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    has_result = 1'b1;
                    if (read_index_reg == commit_index_reg)
                    begin
                        result.kind = KIND_REMPTY;
                    end
                    else if (head_byte == KEY_CTRL_D)
                    begin
                        result.kind     = KIND_REOF;
                        result.out_byte = head_byte;
                        if (in_item_reg.first_of_read)
                        begin
                            read_index_next = idx_inc(read_index_reg);
                        end
                    end
                    else
                    begin
                        read_index_next    = idx_inc(read_index_reg);
                        result.kind        = KIND_RDATA;
                        result.out_byte    = head_byte;
                        result.end_of_line = (head_byte == KEY_LF);
                    end
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `CLE_ASSERT_IMPL(a_index_order, 1'b1, (commit_cnt <= fill_cnt) && (fill_cnt <= IDX_W'(BUF_DEPTH)))
    `CLE_ASSERT_NEXT(a_full_keeps_escape, proc_go && (in_item_reg.op == OP_RECV) && full, $stable(esc_reg))
    `CLE_ASSERT_IMPL(a_stall_cause, !in_ready, in_valid_reg && out_valid_reg && !out_ready)

endmodule

`default_nettype wire
